FILE: design/estc_pkg.sv
// Shared types, constants and fixed-point helpers for the stencil triplet assembly core.
// No dependencies; every other design file refers to this package by scoped names.
package estc_pkg;

   localparam int MAX_PARTICLES = 4096;
   localparam int IDX_W         = 12;
   localparam int ROW_W         = IDX_W + 1;
   localparam int NUM_ENTRIES   = 18;
   localparam int ENT_W         = 5;
   localparam int NUM_CSR       = 6;
   localparam int CSR_ADDR_W    = 5;

   localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;

   localparam logic [2:0] CSR_FIRST_MAIN   = 3'd0;
   localparam logic [2:0] CSR_FIRST_LAME   = 3'd1;
   localparam logic [2:0] CSR_FIRST_SHEAR  = 3'd2;
   localparam logic [2:0] CSR_SECOND_MAIN  = 3'd3;
   localparam logic [2:0] CSR_SECOND_SHEAR = 3'd4;
   localparam logic [2:0] CSR_SECOND_CROSS = 3'd5;

   localparam logic [ENT_W-1:0] E_FIX_X   = 5'd0;
   localparam logic [ENT_W-1:0] E_FIX_Y   = 5'd1;
   localparam logic [ENT_W-1:0] E_TX_XX   = 5'd2;
   localparam logic [ENT_W-1:0] E_TX_XY   = 5'd3;
   localparam logic [ENT_W-1:0] E_TX_SXX  = 5'd4;
   localparam logic [ENT_W-1:0] E_TX_SXY  = 5'd5;
   localparam logic [ENT_W-1:0] E_TY_YX   = 5'd6;
   localparam logic [ENT_W-1:0] E_TY_YY   = 5'd7;
   localparam logic [ENT_W-1:0] E_TY_SYX  = 5'd8;
   localparam logic [ENT_W-1:0] E_TY_SYY  = 5'd9;
   localparam logic [ENT_W-1:0] E_IN_XX   = 5'd10;
   localparam logic [ENT_W-1:0] E_IN_XY   = 5'd11;
   localparam logic [ENT_W-1:0] E_IN_YX   = 5'd12;
   localparam logic [ENT_W-1:0] E_IN_YY   = 5'd13;
   localparam logic [ENT_W-1:0] E_IN_SXX  = 5'd14;
   localparam logic [ENT_W-1:0] E_IN_SXY  = 5'd15;
   localparam logic [ENT_W-1:0] E_IN_SYX  = 5'd16;
   localparam logic [ENT_W-1:0] E_IN_SYY  = 5'd17;

   typedef struct packed {
      logic [IDX_W-1:0]   particle_index;
      logic [IDX_W-1:0]   neighbour_index;
      logic [3:0]         boundary_flags;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] weight_dx;
      logic signed [31:0] weight_dy;
      logic signed [31:0] weight_dxx;
      logic signed [31:0] weight_dyy;
      logic signed [31:0] weight_dxy;
      logic               last_neighbour;
      logic               particle_start;
   } item_type;

   typedef struct packed {
      logic signed [31:0] first_main;
      logic signed [31:0] first_lame;
      logic signed [31:0] first_shear;
      logic signed [31:0] second_main;
      logic signed [31:0] second_shear;
      logic signed [31:0] second_cross;
   } coef_type;

   typedef struct packed {
      logic     push;
      item_type data;
   } push_type;

   typedef struct packed {
      logic     valid;
      logic     full;
      item_type data;
   } queue_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh00_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -40'sh00_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd8388608) >>> 24;
      return sat32(t[39:0]);
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [39:0] s;
      s = 40'(a) + 40'(b);
      return sat32(s);
   endfunction

endpackage

FILE: design/estc_if.sv
// Request and response channel interfaces of the stencil triplet assembly core.
// Depends on estc_pkg for field widths.
interface estc_req_if;
   logic                        valid;
   logic                        ready;
   logic [estc_pkg::IDX_W-1:0]  particle_index;
   logic [estc_pkg::IDX_W-1:0]  neighbour_index;
   logic [3:0]                  boundary_flags;
   logic signed [31:0]          normal_x;
   logic signed [31:0]          normal_y;
   logic signed [31:0]          weight_dx;
   logic signed [31:0]          weight_dy;
   logic signed [31:0]          weight_dxx;
   logic signed [31:0]          weight_dyy;
   logic signed [31:0]          weight_dxy;
   logic                        last_neighbour;

   modport source (output valid, particle_index, neighbour_index, boundary_flags,
                   normal_x, normal_y, weight_dx, weight_dy, weight_dxx, weight_dyy,
                   weight_dxy, last_neighbour, input ready);
   modport sink (input valid, particle_index, neighbour_index, boundary_flags,
                 normal_x, normal_y, weight_dx, weight_dy, weight_dxx, weight_dyy,
                 weight_dxy, last_neighbour, output ready);
endinterface

interface estc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [estc_pkg::ROW_W-1:0]  matrix_row;
   logic [estc_pkg::ROW_W-1:0]  matrix_col;
   logic signed [31:0]          entry_value;
   logic                        run_end;

   modport source (output valid, matrix_row, matrix_col, entry_value, run_end,
                   input ready);
   modport sink (input valid, matrix_row, matrix_col, entry_value, run_end,
                 output ready);
endinterface

FILE: design/elastic_stencil_triplet_assembly_core.sv
// Top level of the stencil triplet assembly core: coefficient registers,
// front end, request queue and back end. Depends on estc_pkg, estc_if and submodules.
//
//  channel   direction  handshake              payload
//  req_ch    in         valid/ready            particle, neighbour, flags, normal, weights, last
//  rsp_ch    out        valid/ready            matrix_row, matrix_col, entry_value, run_end
//  csr_*     in         APB setup/access       six Q8.24 coefficients at 4*i
//
// Each triplet passes a pick state, the products it needs on the shared 32x32
// multiplier and an emit state: no product for unit, sum and mirrored entries, one
// for the interior cross entry, two for the other interior entries, four for
// traction; each request also has a load step and a close-out step.
// Reset is synchronous; no clearing pass is needed.
// The two-entry queue lets the front end keep taking requests while the back end
// waits on a stalled response register.
module elastic_stencil_triplet_assembly_core (
   input  logic                                clock,
   input  logic                                reset,
   estc_req_if.sink                            req_ch,
   estc_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [estc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   estc_pkg::coef_type         coef_ff, coef_in;
   estc_pkg::push_type         push;
   estc_pkg::queue_status_type qstat;
   logic                       pop;
   logic [2:0]                 csr_idx;
   logic                       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            estc_pkg::CSR_FIRST_MAIN:   coef_in.first_main   = csr_pwdata;
            estc_pkg::CSR_FIRST_LAME:   coef_in.first_lame   = csr_pwdata;
            estc_pkg::CSR_FIRST_SHEAR:  coef_in.first_shear  = csr_pwdata;
            estc_pkg::CSR_SECOND_MAIN:  coef_in.second_main  = csr_pwdata;
            estc_pkg::CSR_SECOND_SHEAR: coef_in.second_shear = csr_pwdata;
            estc_pkg::CSR_SECOND_CROSS: coef_in.second_cross = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         estc_pkg::CSR_FIRST_MAIN:   csr_prdata = coef_ff.first_main;
         estc_pkg::CSR_FIRST_LAME:   csr_prdata = coef_ff.first_lame;
         estc_pkg::CSR_FIRST_SHEAR:  csr_prdata = coef_ff.first_shear;
         estc_pkg::CSR_SECOND_MAIN:  csr_prdata = coef_ff.second_main;
         estc_pkg::CSR_SECOND_SHEAR: csr_prdata = coef_ff.second_shear;
         estc_pkg::CSR_SECOND_CROSS: csr_prdata = coef_ff.second_cross;
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   estc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (qstat.full),
      .push_out   (push)
   );

   estc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .status  (qstat)
   );

   estc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .coef   (coef_ff),
      .queue  (qstat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTHESIS
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.valid) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.push |-> !qstat.full) else $error("push into full queue");
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid) else $error("response valid after reset");
`endif

endmodule

FILE: design/estc_front.sv
// Front end: accepts requests, drops out-of-range indexes, tags particle start.
// Depends on estc_pkg and estc_if.
module estc_front (
   input  logic                         clock,
   input  logic                         reset,
   estc_req_if.sink                     req_ch,
   input  logic                         queue_full,
   output estc_pkg::push_type           push_out
);

   logic start_ff, start_in;
   logic accept, in_range;

   assign req_ch.ready = !queue_full;
   assign accept   = req_ch.valid && !queue_full;
   assign in_range = (32'(req_ch.particle_index) < estc_pkg::MAX_PARTICLES) &&
                     (32'(req_ch.neighbour_index) < estc_pkg::MAX_PARTICLES);

   always_comb begin
      start_in = start_ff;
      if (accept && in_range) begin
         start_in = req_ch.last_neighbour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
      end else begin
         start_ff <= start_in;
      end
   end

   always_comb begin
      push_out.push                 = accept && in_range;
      push_out.data.particle_index  = req_ch.particle_index;
      push_out.data.neighbour_index = req_ch.neighbour_index;
      push_out.data.boundary_flags  = req_ch.boundary_flags;
      push_out.data.normal_x        = req_ch.normal_x;
      push_out.data.normal_y        = req_ch.normal_y;
      push_out.data.weight_dx       = req_ch.weight_dx;
      push_out.data.weight_dy       = req_ch.weight_dy;
      push_out.data.weight_dxx      = req_ch.weight_dxx;
      push_out.data.weight_dyy      = req_ch.weight_dyy;
      push_out.data.weight_dxy      = req_ch.weight_dxy;
      push_out.data.last_neighbour  = req_ch.last_neighbour;
      push_out.data.particle_start  = start_ff;
   end

endmodule

FILE: design/estc_queue.sv
// Two-entry request queue between front end and back end.
// Depends on estc_pkg.
module estc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  estc_pkg::push_type          push_in,
   input  logic                        pop,
   output estc_pkg::queue_status_type  status
);

   estc_pkg::item_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_in.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push_in.push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         mem[wr_ptr_ff] <= push_in.data;
      end
   end

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign status.data  = mem[rd_ptr_ff];

endmodule

FILE: design/estc_back.sv
// Back end: walks the triplets of one request through a shared multiplier,
// keeps the diagonal accumulators and drives the response register.
// Depends on estc_pkg and estc_if.
module estc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  estc_pkg::coef_type          coef,
   input  estc_pkg::queue_status_type  queue,
   output logic                        pop,
   estc_rsp_if.source                  rsp_ch
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PICK = 2'd1;
   localparam logic [1:0] S_CALC = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   estc_pkg::item_type item_ff, item_in;
   logic [estc_pkg::NUM_ENTRIES-1:0] mask_ff, mask_in, new_mask, ent_bit;
   logic [estc_pkg::ENT_W-1:0] ent_ff, ent_in, lowest;
   logic [2:0] ph_ff, ph_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [31:0] r_ff, r_in, t1_ff, t1_in, copy_ff, copy_in;
   logic signed [31:0] sxx_ff, sxx_in, sxy_ff, sxy_in, syx_ff, syx_in, syy_ff, syy_in;
   logic signed [31:0] c1, x1, w1, c2, x2, w2, mul_a, mul_b, value;
   logic three, has_t2, is_calc;
   logic [estc_pkg::ROW_W-1:0] rx, ry, cx, cy, row, col;
   logic out_free;
   logic rsp_valid_ff, rsp_valid_in, rsp_end_ff, rsp_end_in;
   logic [estc_pkg::ROW_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic f0, f1, f2, f3, fz, st, lst;

   assign f0  = queue.data.boundary_flags[0];
   assign f1  = queue.data.boundary_flags[1];
   assign f2  = queue.data.boundary_flags[2];
   assign f3  = queue.data.boundary_flags[3];
   assign fz  = (queue.data.boundary_flags == 4'd0);
   assign st  = queue.data.particle_start;
   assign lst = queue.data.last_neighbour;

   always_comb begin
      new_mask = '0;
      new_mask[estc_pkg::E_FIX_X]  = st & f0;
      new_mask[estc_pkg::E_FIX_Y]  = st & f1;
      new_mask[estc_pkg::E_TX_XX]  = f2;
      new_mask[estc_pkg::E_TX_XY]  = f2;
      new_mask[estc_pkg::E_TX_SXX] = f2 & lst;
      new_mask[estc_pkg::E_TX_SXY] = f2 & lst;
      new_mask[estc_pkg::E_TY_YX]  = f3;
      new_mask[estc_pkg::E_TY_YY]  = f3;
      new_mask[estc_pkg::E_TY_SYX] = f3 & lst;
      new_mask[estc_pkg::E_TY_SYY] = f3 & lst;
      new_mask[estc_pkg::E_IN_XX]  = fz;
      new_mask[estc_pkg::E_IN_XY]  = fz;
      new_mask[estc_pkg::E_IN_YX]  = fz;
      new_mask[estc_pkg::E_IN_YY]  = fz;
      new_mask[estc_pkg::E_IN_SXX] = fz & lst;
      new_mask[estc_pkg::E_IN_SXY] = fz & lst;
      new_mask[estc_pkg::E_IN_SYX] = fz & lst;
      new_mask[estc_pkg::E_IN_SYY] = fz & lst;
   end

   always_comb begin
      lowest = '0;
      for (int i = estc_pkg::NUM_ENTRIES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            lowest = estc_pkg::ENT_W'(i);
         end
      end
   end

   assign ent_bit = estc_pkg::NUM_ENTRIES'(1) << ent_ff;

   assign rx = {item_ff.particle_index, 1'b0};
   assign ry = {item_ff.particle_index, 1'b1};
   assign cx = {item_ff.neighbour_index, 1'b0};
   assign cy = {item_ff.neighbour_index, 1'b1};

   always_comb begin
      c1 = coef.second_cross; x1 = item_ff.weight_dxy; w1 = '0;
      c2 = '0; x2 = '0; w2 = '0;
      three = 1'b0; has_t2 = 1'b0; is_calc = 1'b0;
      row = rx; col = rx;
      unique case (ent_ff)
         estc_pkg::E_FIX_X:  begin row = rx; col = rx; end
         estc_pkg::E_FIX_Y:  begin row = ry; col = ry; end
         estc_pkg::E_TX_XX: begin
            row = rx; col = cx; is_calc = 1'b1; three = 1'b1; has_t2 = 1'b1;
            c1 = coef.first_main;  x1 = item_ff.normal_x; w1 = item_ff.weight_dx;
            c2 = coef.first_shear; x2 = item_ff.normal_y; w2 = item_ff.weight_dy;
         end
         estc_pkg::E_TX_XY: begin
            row = rx; col = cy; is_calc = 1'b1; three = 1'b1; has_t2 = 1'b1;
            c1 = coef.first_lame;  x1 = item_ff.normal_x; w1 = item_ff.weight_dy;
            c2 = coef.first_shear; x2 = item_ff.normal_y; w2 = item_ff.weight_dx;
         end
         estc_pkg::E_TX_SXX: begin row = rx; col = rx; end
         estc_pkg::E_TX_SXY: begin row = rx; col = ry; end
         estc_pkg::E_TY_YX: begin
            row = ry; col = cx; is_calc = 1'b1; three = 1'b1; has_t2 = 1'b1;
            c1 = coef.first_lame;  x1 = item_ff.normal_y; w1 = item_ff.weight_dx;
            c2 = coef.first_shear; x2 = item_ff.normal_x; w2 = item_ff.weight_dy;
         end
         estc_pkg::E_TY_YY: begin
            row = ry; col = cy; is_calc = 1'b1; three = 1'b1; has_t2 = 1'b1;
            c1 = coef.first_main;  x1 = item_ff.normal_y; w1 = item_ff.weight_dy;
            c2 = coef.first_shear; x2 = item_ff.normal_x; w2 = item_ff.weight_dx;
         end
         estc_pkg::E_TY_SYX: begin row = ry; col = rx; end
         estc_pkg::E_TY_SYY: begin row = ry; col = ry; end
         estc_pkg::E_IN_XX: begin
            row = rx; col = cx; is_calc = 1'b1; has_t2 = 1'b1;
            c1 = coef.second_main;  x1 = item_ff.weight_dxx;
            c2 = coef.second_shear; x2 = item_ff.weight_dyy;
         end
         estc_pkg::E_IN_XY: begin
            row = rx; col = cy; is_calc = 1'b1;
            c1 = coef.second_cross; x1 = item_ff.weight_dxy;
         end
         estc_pkg::E_IN_YX: begin row = ry; col = cx; end
         estc_pkg::E_IN_YY: begin
            row = ry; col = cy; is_calc = 1'b1; has_t2 = 1'b1;
            c1 = coef.second_main;  x1 = item_ff.weight_dyy;
            c2 = coef.second_shear; x2 = item_ff.weight_dxx;
         end
         estc_pkg::E_IN_SXX: begin row = rx; col = rx; end
         estc_pkg::E_IN_SXY: begin row = rx; col = ry; end
         estc_pkg::E_IN_SYX: begin row = ry; col = rx; end
         estc_pkg::E_IN_SYY: begin row = ry; col = ry; end
         default: begin row = rx; col = rx; end
      endcase
   end

   always_comb begin
      unique case (ph_ff[2:1])
         2'd0: begin mul_a = c1;   mul_b = x1; end
         2'd1: begin mul_a = r_ff; mul_b = w1; end
         2'd2: begin mul_a = c2;   mul_b = x2; end
         2'd3: begin mul_a = r_ff; mul_b = w2; end
         default: begin mul_a = c1; mul_b = x1; end
      endcase
   end

   always_comb begin
      priority case (ent_ff)
         estc_pkg::E_FIX_X, estc_pkg::E_FIX_Y:   value = estc_pkg::ONE_Q24;
         estc_pkg::E_TX_SXX, estc_pkg::E_IN_SXX: value = sxx_ff;
         estc_pkg::E_TX_SXY, estc_pkg::E_IN_SXY: value = sxy_ff;
         estc_pkg::E_TY_SYX, estc_pkg::E_IN_SYX: value = syx_ff;
         estc_pkg::E_TY_SYY, estc_pkg::E_IN_SYY: value = syy_ff;
         estc_pkg::E_IN_YX:                      value = copy_ff;
         default: value = has_t2 ? estc_pkg::add_sat(t1_ff, r_ff) : r_ff;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff; item_in = item_ff; mask_in = mask_ff; ent_in = ent_ff;
      ph_in = ph_ff; p_in = p_ff; r_in = r_ff; t1_in = t1_ff; copy_in = copy_ff;
      sxx_in = sxx_ff; sxy_in = sxy_ff; syx_in = syx_ff; syy_in = syy_ff;
      pop = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_row_in = rsp_row_ff; rsp_col_in = rsp_col_ff;
      rsp_val_in = rsp_val_ff; rsp_end_in = rsp_end_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (queue.valid) begin
               pop      = 1'b1;
               item_in  = queue.data;
               mask_in  = new_mask;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (mask_ff == '0) begin
               if (item_ff.last_neighbour) begin
                  sxx_in = '0; sxy_in = '0; syx_in = '0; syy_in = '0;
               end
               state_in = S_IDLE;
            end else begin
               ent_in   = lowest;
               ph_in    = 3'd0;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (!is_calc) begin
               state_in = S_EMIT;
            end else if (!ph_ff[0]) begin
               p_in  = mul_a * mul_b;
               ph_in = ph_ff + 3'd1;
               if (ph_ff == 3'd4) begin
                  t1_in = r_ff;
               end
            end else begin
               r_in = estc_pkg::round_sat(p_ff);
               priority if (ph_ff[1] == 1'b0 && three) begin
                  ph_in = ph_ff + 3'd1;
               end else if (ph_ff[2] == 1'b0 && has_t2) begin
                  ph_in = 3'd4;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row;
               rsp_col_in   = col;
               rsp_val_in   = value;
               rsp_end_in   = ((mask_ff & ~ent_bit) == '0);
               mask_in      = mask_ff & ~ent_bit;
               state_in     = S_PICK;
               priority case (ent_ff)
                  estc_pkg::E_TX_XX, estc_pkg::E_IN_XX:
                     sxx_in = estc_pkg::add_sat(sxx_ff, value);
                  estc_pkg::E_TX_XY, estc_pkg::E_IN_XY:
                     sxy_in = estc_pkg::add_sat(sxy_ff, value);
                  estc_pkg::E_TY_YX, estc_pkg::E_IN_YX:
                     syx_in = estc_pkg::add_sat(syx_ff, value);
                  estc_pkg::E_TY_YY, estc_pkg::E_IN_YY:
                     syy_in = estc_pkg::add_sat(syy_ff, value);
                  default: ;
               endcase
               if (ent_ff == estc_pkg::E_IN_XY) begin
                  copy_in = value;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sxx_ff <= '0; sxy_ff <= '0; syx_ff <= '0; syy_ff <= '0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         sxx_ff <= sxx_in; sxy_ff <= sxy_in; syx_ff <= syx_in; syy_ff <= syy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      ent_ff     <= ent_in;
      ph_ff      <= ph_in;
      p_ff       <= p_in;
      r_ff       <= r_in;
      t1_ff      <= t1_in;
      copy_ff    <= copy_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_val_ff <= rsp_val_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.matrix_row  = rsp_row_ff;
   assign rsp_ch.matrix_col  = rsp_col_ff;
   assign rsp_ch.entry_value = rsp_val_ff;
   assign rsp_ch.run_end     = rsp_end_ff;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for elastic_stencil_triplet_assembly_core: random and directed
// requests, an APB coefficient port and a scoreboard class predicting every triplet.
// Depends on estc_pkg and the channel interfaces in estc_if.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [estc_pkg::IDX_W-1:0] particle;
      logic [estc_pkg::IDX_W-1:0] neighbour;
      logic [3:0]                 flags;
      logic signed [31:0]         nx, ny, dx, dy, dxx, dyy, dxy;
      logic                       last;
   } stencil_req_type;

   typedef struct {
      logic [estc_pkg::ROW_W-1:0] row;
      logic [estc_pkg::ROW_W-1:0] col;
      logic signed [31:0]         value;
      logic                       run_end;
   } triplet_type;

   class triplet_scoreboard;
      triplet_type triplets_due[$];
      longint      coef[estc_pkg::NUM_CSR];
      longint      sum_xx, sum_xy, sum_yx, sum_yy;
      bit          particle_start;
      int          errors;
      triplet_type batch[$];

      function new();
         foreach (coef[i]) coef[i] = 0;
         sum_xx = 0; sum_xy = 0; sum_yx = 0; sum_yy = 0;
         particle_start = 1;
         errors = 0;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint mulq(longint a, longint b);
         longint p;
         p = a * b + 64'sd8388608;
         return sat(p >>> 24);
      endfunction

      function longint mul3(longint c, longint n, longint w);
         return mulq(mulq(c, n), w);
      endfunction

      function void push(int row, int col, longint v);
         triplet_type t;
         t.row = row[estc_pkg::ROW_W-1:0];
         t.col = col[estc_pkg::ROW_W-1:0];
         t.value = v[31:0];
         t.run_end = 0;
         batch.insert(batch.size(), t);
      endfunction

      function void note_request(stencil_req_type r);
         int     rx, ry, cx, cy;
         longint nx, ny, dx, dy, dxx, dyy, dxy, v;
         rx = 2 * r.particle; ry = rx + 1;
         cx = 2 * r.neighbour; cy = cx + 1;
         nx = r.nx; ny = r.ny; dx = r.dx; dy = r.dy;
         dxx = r.dxx; dyy = r.dyy; dxy = r.dxy;
         batch.delete();
         if (particle_start) begin
            if (r.flags[0]) push(rx, rx, estc_pkg::ONE_Q24);
            if (r.flags[1]) push(ry, ry, estc_pkg::ONE_Q24);
         end
         if (r.flags[2]) begin
            v = sat(mul3(coef[estc_pkg::CSR_FIRST_MAIN], nx, dx) +
                    mul3(coef[estc_pkg::CSR_FIRST_SHEAR], ny, dy));
            push(rx, cx, v); sum_xx = sat(sum_xx + v);
            v = sat(mul3(coef[estc_pkg::CSR_FIRST_LAME], nx, dy) +
                    mul3(coef[estc_pkg::CSR_FIRST_SHEAR], ny, dx));
            push(rx, cy, v); sum_xy = sat(sum_xy + v);
            if (r.last) begin
               push(rx, rx, sum_xx); push(rx, ry, sum_xy);
            end
         end
         if (r.flags[3]) begin
            v = sat(mul3(coef[estc_pkg::CSR_FIRST_LAME], ny, dx) +
                    mul3(coef[estc_pkg::CSR_FIRST_SHEAR], nx, dy));
            push(ry, cx, v); sum_yx = sat(sum_yx + v);
            v = sat(mul3(coef[estc_pkg::CSR_FIRST_MAIN], ny, dy) +
                    mul3(coef[estc_pkg::CSR_FIRST_SHEAR], nx, dx));
            push(ry, cy, v); sum_yy = sat(sum_yy + v);
            if (r.last) begin
               push(ry, rx, sum_yx); push(ry, ry, sum_yy);
            end
         end
         if (r.flags == 4'd0) begin
            v = sat(mulq(coef[estc_pkg::CSR_SECOND_MAIN], dxx) +
                    mulq(coef[estc_pkg::CSR_SECOND_SHEAR], dyy));
            push(rx, cx, v); sum_xx = sat(sum_xx + v);
            v = mulq(coef[estc_pkg::CSR_SECOND_CROSS], dxy);
            push(rx, cy, v); sum_xy = sat(sum_xy + v);
            push(ry, cx, v); sum_yx = sat(sum_yx + v);
            v = sat(mulq(coef[estc_pkg::CSR_SECOND_MAIN], dyy) +
                    mulq(coef[estc_pkg::CSR_SECOND_SHEAR], dxx));
            push(ry, cy, v); sum_yy = sat(sum_yy + v);
            if (r.last) begin
               push(rx, rx, sum_xx); push(rx, ry, sum_xy);
               push(ry, rx, sum_yx); push(ry, ry, sum_yy);
            end
         end
         if (r.last) begin
            sum_xx = 0; sum_xy = 0; sum_yx = 0; sum_yy = 0;
            particle_start = 1;
         end else begin
            particle_start = 0;
         end
         if (batch.size() > 0) batch[batch.size() - 1].run_end = 1;
         foreach (batch[i]) triplets_due.insert(triplets_due.size(), batch[i]);
      endfunction

      function void check_response(triplet_type got);
         triplet_type exp;
         if (triplets_due.size() == 0) begin
            $display("%0t: unexpected triplet row %0d col %0d value %h end %0d",
                     $time, got.row, got.col, got.value, got.run_end);
            errors++;
            return;
         end
         exp = triplets_due.pop_front();
         if (got.row !== exp.row || got.col !== exp.col || got.value !== exp.value ||
             got.run_end !== exp.run_end) begin
            $display("%0t: mismatch expected row %0d col %0d value %h end %0d",
                     $time, exp.row, exp.col, exp.value, exp.run_end);
            $display("%0t:          actual   row %0d col %0d value %h end %0d",
                     $time, got.row, got.col, got.value, got.run_end);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [estc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          send_idle = 0, rcv_idle = 0;
   bit          rsp_hold = 0;
   int          csr_errors = 0;

   estc_req_if req_bus();
   estc_rsp_if rsp_bus();
   triplet_scoreboard sb = new();

   elastic_stencil_triplet_assembly_core DUT (
      .clock(clock), .reset(reset), .req_ch(req_bus), .rsp_ch(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.particle_index = '0; req_bus.neighbour_index = '0;
      req_bus.boundary_flags = '0; req_bus.normal_x = '0; req_bus.normal_y = '0;
      req_bus.weight_dx = '0; req_bus.weight_dy = '0; req_bus.weight_dxx = '0;
      req_bus.weight_dyy = '0; req_bus.weight_dxy = '0; req_bus.last_neighbour = 0;
      rsp_bus.ready = 0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= rcv_idle);
   end

   always @(posedge clock) begin
      triplet_type t;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         t.row = rsp_bus.matrix_row; t.col = rsp_bus.matrix_col;
         t.value = rsp_bus.entry_value; t.run_end = rsp_bus.run_end;
         sb.check_response(t);
      end
   end

   task automatic csr_access(input logic [2:0] idx, input logic wr, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= wr;
      csr_paddr <= estc_pkg::CSR_ADDR_W'({idx, 2'b00}); csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      if (!wr && csr_prdata !== data) begin
         $display("%0t: register %0d readback expected %h actual %h",
                  $time, idx, data, csr_prdata);
         csr_errors++;
      end
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0;
   endtask

   task automatic load_coefs(input logic [31:0] c0, c1, c2, c3, c4, c5);
      logic [31:0] vals[estc_pkg::NUM_CSR];
      vals = '{c0, c1, c2, c3, c4, c5};
      foreach (vals[i]) begin
         csr_access(3'(i), 1, vals[i]);
         csr_access(3'(i), 0, vals[i]);
         sb.coef[i] = longint'(signed'(vals[i]));
      end
   endtask

   task automatic send_request(input stencil_req_type r);
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_bus.valid <= 0;
      end
      @(negedge clock);
      req_bus.particle_index <= r.particle; req_bus.neighbour_index <= r.neighbour;
      req_bus.boundary_flags <= r.flags; req_bus.normal_x <= r.nx; req_bus.normal_y <= r.ny;
      req_bus.weight_dx <= r.dx; req_bus.weight_dy <= r.dy; req_bus.weight_dxx <= r.dxx;
      req_bus.weight_dyy <= r.dyy; req_bus.weight_dxy <= r.dxy;
      req_bus.last_neighbour <= r.last;
      req_bus.valid <= 1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
   endtask

   task automatic send(input int p, nb, input logic [3:0] fl,
                       input logic [31:0] nx, ny, dx, dy, dxx, dyy, dxy, input bit last);
      stencil_req_type r;
      r.particle = p[estc_pkg::IDX_W-1:0]; r.neighbour = nb[estc_pkg::IDX_W-1:0];
      r.flags = fl;
      r.nx = nx; r.ny = ny; r.dx = dx; r.dy = dy;
      r.dxx = dxx; r.dyy = dyy; r.dxy = dxy; r.last = last;
      send_request(r);
   endtask

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   task automatic send_particles(input int count);
      int          p, len, sent;
      logic [3:0]  fl;
      sent = 0;
      while (sent < count) begin
         p = $urandom_range(4095);
         len = $urandom_range(1, 4);
         fl = ($urandom_range(9) < 4) ? 4'd0 : 4'($urandom_range(15));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) fl = 4'($urandom_range(15));
            send(p, $urandom_range(4095), fl, rand_weight(), rand_weight(), rand_weight(),
                 rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                 (i == len - 1) && ($urandom_range(19) != 0));
            sent++;
         end
      end
      @(negedge clock);
      req_bus.valid <= 0;
   endtask

   task automatic drain();
      while (sb.triplets_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

   initial begin
      logic [31:0] one, half;
      one = estc_pkg::ONE_Q24; half = 32'h0080_0000;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_idle = 27; rcv_idle = 81;
      load_coefs(32'h0300_0000, one, half, 32'h0C00_0000, 32'h0200_0000, 32'h0400_0000);
      send(0, 0, 4'b0011, one, 0, one, one, one, one, one, 0);
      send(0, 1, 4'b0011, one, 0, one, one, one, one, one, 1);
      send(5, 6, 4'b0100, one, half, one, -one, 0, 0, 0, 0);
      send(5, 7, 4'b0100, half, one, -half, one, 0, 0, 0, 1);
      send(9, 10, 4'b1000, 0, one, one, one, 0, 0, 0, 1);
      send(11, 12, 4'b1111, one, one, one, one, one, one, one, 1);
      send(20, 21, 4'b0000, 0, 0, 0, 0, one, half, one, 0);
      send(20, 22, 4'b0000, 0, 0, 0, 0, -one, one, half, 0);
      send(20, 23, 4'b0000, 0, 0, 0, 0, half, -half, -one, 1);
      send(30, 31, 4'b0000, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
      send(4095, 4095, 4'b0000, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
           32'h7FFF_FFFF, 1);
      send(40, 0, 4'b1100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
           0, 0, 0, 1);
      send(7, 8, 4'b0000, 0, 0, 0, 0, one, one, one, 0);
      send(8, 9, 4'b0000, 0, 0, 0, 0, one, one, one, 1);
      send(50, 51, 4'b0101, one, 0, one, 0, 0, 0, 0, 1);
      send(52, 53, 4'b1010, 0, one, 0, one, 0, 0, 0, 1);
      send_particles(30);
      drain();

      send_idle = 81; rcv_idle = 27;
      load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000);
      send_particles(30);
      drain();

      send_idle = 0; rcv_idle = 0;
      load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      fork
         begin
            rsp_hold = 1;
            repeat (400) @(posedge clock);
            rsp_hold = 0;
         end
      join_none
      send_particles(34);
      drain();

      if (sb.errors == 0 && csr_errors == 0 && sb.triplets_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule

FILE: elastic_stencil_triplet_assembly_core.f
design/estc_pkg.sv
design/estc_if.sv
design/estc_front.sv
design/estc_queue.sv
design/estc_back.sv
design/elastic_stencil_triplet_assembly_core.sv
sim/tb.sv
